[design/ctb_pkg.sv]
`timescale 1ns / 1ps

package ctb_pkg;

  localparam int ID_W    = 11;
  localparam int W_W     = 32;
  localparam int REQ_W   = 2;
  localparam int ST_W    = 2;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 48;
  localparam int OUT_PAD = OUT_DW - (4 * ID_W + ST_W);

  // request kinds
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // result status
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_ID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic accept;     // latch the input item, start store reads
    logic pop;        // drop the spine top
    logic fetch;      // load the new spine top from the stack store
    logic link;       // write the new node, push it, load the result
    logic fix;        // back-patch the popped child and the parent
    logic clr_start;  // empty the spine, restart the clearing sweep
    logic clr_step;   // clear one presence entry
    logic out_eval;   // load a query, error, clear or no-op result
  } cmd_t;

  typedef struct packed {
    logic append_ok;
    logic is_clear;
    logic pop_go;
    logic below;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

[design/ctb_ctrl.sv]
`timescale 1ns / 1ps

module ctb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ctb_pkg::sts_t sts,
  output ctb_pkg::cmd_t cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_FIX   = 3'd6;
  localparam logic [2:0] S_CLR   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       pop_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pop_step  = 1'b0;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (sts.is_clear) begin
          cmd.clr_start = 1'b1;
          state_nxt     = S_CLR;
        end else if (sts.append_ok) begin
          pop_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.out_eval = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_EVAL;  // previous result still waiting
        end
      end
      S_POP: begin
        pop_step = 1'b1;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_POP;
      end
      S_LINK: begin
        if (sts.out_free) begin
          cmd.link  = 1'b1;
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last && sts.out_free) begin
          cmd.out_eval = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // one spine compare per step; a pop with entries left needs a store read
    if (pop_step) begin
      if (sts.pop_go) begin
        cmd.pop   = 1'b1;
        state_nxt = sts.below ? S_FETCH : S_LINK;
      end else begin
        state_nxt = S_LINK;
      end
    end
  end

endmodule

[design/ctb_dp.sv]
`timescale 1ns / 1ps

module ctb_dp #(
  parameter int MAX_NODES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctb_pkg::cmd_t              cmd,
  output ctb_pkg::sts_t              sts,
  input  logic [ctb_pkg::IN_DW-1:0]  in_tdata,
  input  logic [ctb_pkg::REQ_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ctb_pkg::OUT_DW-1:0] out_tdata
);

  localparam int ID_W = ctb_pkg::ID_W;
  localparam int W_W  = ctb_pkg::W_W;
  localparam int AW   = $clog2(MAX_NODES);
  localparam int DW   = $clog2(MAX_NODES + 1);
  localparam int CW   = ((ID_W > AW) ? ID_W : AW) + 1;

  // stores
  logic                pres_mem   [MAX_NODES];
  logic [ID_W-1:0]     par_mem    [MAX_NODES];
  logic [ID_W-1:0]     lft_mem    [MAX_NODES];
  logic [ID_W-1:0]     rgt_mem    [MAX_NODES];
  logic [ID_W-1:0]     stk_id_mem [MAX_NODES];
  logic [W_W-1:0]      stk_w_mem  [MAX_NODES];

  logic                pres_q;
  logic [ID_W-1:0]     par_q;
  logic [ID_W-1:0]     lft_q;
  logic [ID_W-1:0]     rgt_q;
  logic [ID_W-1:0]     stk_id_q;
  logic [W_W-1:0]      stk_w_q;

  // item and spine registers
  logic [ctb_pkg::REQ_W-1:0] req_r;
  logic [ID_W-1:0]           id_r;
  logic signed [W_W-1:0]     w_r;
  logic [DW-1:0]             depth_r;
  logic [DW-1:0]             count_r;
  logic [ID_W-1:0]           root_r;
  logic [ID_W-1:0]           top_id_r;
  logic signed [W_W-1:0]     top_w_r;
  logic [ID_W-1:0]           popped_r;
  logic [ID_W-1:0]           par_r;
  logic [AW-1:0]             clr_addr_r;
  logic                      out_valid_r;
  logic [ctb_pkg::OUT_DW-1:0] out_data_r;

  logic [ID_W-1:0]     in_id;
  logic [CW-1:0]       in_ext;
  logic [AW-1:0]       in_addr;
  logic [CW-1:0]       id_ext;
  logic [AW-1:0]       id_addr;
  logic [CW-1:0]       popped_ext;
  logic [AW-1:0]       popped_addr;
  logic [CW-1:0]       par_ext;
  logic [AW-1:0]       par_addr;
  logic [DW-1:0]       below_idx;
  logic                id_ok;
  logic                full;
  logic                clr_last;
  logic                out_free;
  logic [ID_W-1:0]     par_now;
  logic [ID_W-1:0]     root_now;
  logic [ID_W-1:0]     root_after;
  logic [ID_W-1:0]     eval_par;
  logic [ID_W-1:0]     eval_lft;
  logic [ID_W-1:0]     eval_rgt;
  logic [ctb_pkg::ST_W-1:0] eval_st;

  // ids 1..MAX_NODES map to store rows 0..MAX_NODES-1
  assign in_id       = in_tdata[ID_W-1:0];
  assign in_ext      = CW'(in_id) - CW'(1);
  assign in_addr     = in_ext[AW-1:0];
  assign id_ext      = CW'(id_r) - CW'(1);
  assign id_addr     = id_ext[AW-1:0];
  assign popped_ext  = CW'(popped_r) - CW'(1);
  assign popped_addr = popped_ext[AW-1:0];
  assign par_ext     = CW'(par_r) - CW'(1);
  assign par_addr    = par_ext[AW-1:0];
  assign below_idx   = depth_r - DW'(2);

  assign id_ok      = (id_r != '0) && (CW'(id_r) <= CW'(MAX_NODES));
  assign full       = (count_r == DW'(MAX_NODES));
  assign clr_last   = (clr_addr_r == AW'(MAX_NODES - 1));
  assign out_free   = !out_valid_r || out_tready;
  assign par_now    = (depth_r != '0) ? top_id_r : '0;
  assign root_now   = (depth_r != '0) ? root_r : '0;
  assign root_after = (depth_r != '0) ? root_r : id_r;

  always_comb begin
    sts           = '0;
    sts.append_ok = (req_r == ctb_pkg::REQ_APPEND) && id_ok && !full && !pres_q;
    sts.is_clear  = (req_r == ctb_pkg::REQ_CLEAR);
    sts.pop_go    = (depth_r != '0) && (top_w_r > w_r);
    sts.below     = (depth_r > DW'(1));
    sts.clr_last  = clr_last;
    sts.out_free  = out_free;
  end

  always_comb begin
    eval_par = '0;
    eval_lft = '0;
    eval_rgt = '0;
    eval_st  = ctb_pkg::ST_OK;
    unique case (req_r)
      ctb_pkg::REQ_APPEND: begin
        priority if (!id_ok) eval_st = ctb_pkg::ST_BAD_ID;
        else if (full)       eval_st = ctb_pkg::ST_FULL;
        else if (pres_q)     eval_st = ctb_pkg::ST_BAD_ID;
        else                 eval_st = ctb_pkg::ST_OK;
      end
      ctb_pkg::REQ_QUERY: begin
        priority if (!id_ok) begin
          eval_st = ctb_pkg::ST_BAD_ID;
        end else if (!pres_q) begin
          eval_st = ctb_pkg::ST_ABSENT;
        end else begin
          eval_par = par_q;
          eval_lft = lft_q;
          eval_rgt = rgt_q;
        end
      end
      default: begin
        // clear and reserved kinds report only the root
      end
    endcase
  end

  // presence store
  always_ff @(posedge clk) begin
    if (cmd.link || cmd.clr_step) begin
      pres_mem[cmd.link ? id_addr : clr_addr_r] <= cmd.link;
    end
    if (cmd.accept) begin
      pres_q <= pres_mem[in_addr];
    end
  end

  // link stores: the node itself on link, its neighbors on fix
  always_ff @(posedge clk) begin
    if (cmd.link || (cmd.fix && popped_r != '0)) begin
      par_mem[cmd.link ? id_addr : popped_addr] <= cmd.link ? par_now : id_r;
    end
    if (cmd.accept) begin
      par_q <= par_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link) begin
      lft_mem[id_addr] <= popped_r;
    end
    if (cmd.accept) begin
      lft_q <= lft_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link || (cmd.fix && par_r != '0)) begin
      rgt_mem[cmd.link ? id_addr : par_addr] <= cmd.link ? '0 : id_r;
    end
    if (cmd.accept) begin
      rgt_q <= rgt_mem[in_addr];
    end
  end

  // spine stack below the cached top
  always_ff @(posedge clk) begin
    if (cmd.link) begin
      stk_id_mem[depth_r[AW-1:0]] <= id_r;
      stk_w_mem[depth_r[AW-1:0]]  <= w_r;
    end
    if (cmd.pop) begin
      stk_id_q <= stk_id_mem[below_idx[AW-1:0]];
      stk_w_q  <= stk_w_mem[below_idx[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pop) begin
        depth_r <= depth_r - DW'(1);
      end else if (cmd.link) begin
        depth_r <= depth_r + DW'(1);
        count_r <= count_r + DW'(1);
      end else if (cmd.clr_start) begin
        depth_r <= '0;
        count_r <= '0;
      end
      if (cmd.clr_start) begin
        clr_addr_r <= '0;
      end else if (cmd.clr_step && !clr_last) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.link || cmd.out_eval) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_tuser;
      id_r     <= in_id;
      w_r      <= in_tdata[ID_W+W_W-1:ID_W];
      popped_r <= '0;
    end
    if (cmd.pop) begin
      popped_r <= top_id_r;
    end
    if (cmd.fetch) begin
      top_id_r <= stk_id_q;
      top_w_r  <= stk_w_q;
    end
    if (cmd.link) begin
      top_id_r <= id_r;
      top_w_r  <= w_r;
      par_r    <= par_now;
      if (depth_r == '0) root_r <= id_r;
    end
    if (cmd.link) begin
      out_data_r <= {{ctb_pkg::OUT_PAD{1'b0}}, ctb_pkg::ST_OK, root_after,
                     {ID_W{1'b0}}, popped_r, par_now};
    end else if (cmd.out_eval) begin
      out_data_r <= {{ctb_pkg::OUT_PAD{1'b0}}, eval_st, root_now,
                     eval_rgt, eval_lft, eval_par};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[design/cartesian_tree_builder.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   tuser: req_type; tdata: node_id, weight
// out_     out  out_tvalid/tready  tdata: parent_id, left_id, right_id, root_id, status
//
// One item at a time. Query, error, no-op: accept, then evaluate and load the result.
// Append: accept, spine compares, a store read per pop that leaves the spine non-empty, then link, fix.
// Clear: sweeps all MAX_NODES presence rows, one presence row cleared per cycle.
// After reset a sweep clears the presence store, in_tready low.
// A finished result waits in the output register; the next item is taken meanwhile,
// and its result step holds until that register is free.

module cartesian_tree_builder #(
  parameter int MAX_NODES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [10:0] node_id, [42:11] weight, [47:43] zero
  input  logic [ctb_pkg::IN_DW-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [ctb_pkg::REQ_W-1:0]   in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [10:0] parent_id, [21:11] left_id, [32:22] right_id, [43:33] root_id,
  // [45:44] status, [47:46] zero
  output logic [ctb_pkg::OUT_DW-1:0]  out_tdata
);

  ctb_pkg::cmd_t cmd;
  ctb_pkg::sts_t sts;

  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctb_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a result never overwrites one that is still waiting
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.link || cmd.out_eval) |-> sts.out_free)
    else $error("result loaded while output register busy");

  // back-patching follows the node write directly
  a_fix_after_link: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |-> $past(cmd.link))
    else $error("link fix without preceding link");

  // the new spine top is loaded only right after a pop
  a_fetch_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> $past(cmd.pop))
    else $error("spine fetch without pop");

  // an accepted item holds off the next one in the following cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while busy");

endmodule

[bench/tb_cartesian_tree_builder.sv]
`timescale 1ns / 1ps

module tb_cartesian_tree_builder;

  localparam int MAX_NODES = 1024;
  localparam int ID_W      = ctb_pkg::ID_W;
  localparam int REQ_W     = ctb_pkg::REQ_W;
  localparam int ST_W      = ctb_pkg::ST_W;
  localparam int IN_DW     = ctb_pkg::IN_DW;
  localparam int OUT_DW    = ctb_pkg::OUT_DW;
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;  // reserved kind, does nothing

  typedef struct packed {
    logic [ID_W-1:0] parent;
    logic [ID_W-1:0] left;
    logic [ID_W-1:0] right;
    logic [ID_W-1:0] root;
    logic [ST_W-1:0] status;
  } link_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata;
  logic [REQ_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;

  cartesian_tree_builder #(.MAX_NODES(MAX_NODES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("** cartesian_tree_builder: FAILED **");
    $finish;
  end

  // shadow tree
  logic [ID_W-1:0]   spine_id [0:MAX_NODES-1];
  logic signed [31:0] spine_wt [0:MAX_NODES-1];
  int                spine_top;
  int                n_nodes;
  logic [ID_W-1:0]   parent_of [1:MAX_NODES];
  logic [ID_W-1:0]   left_of   [1:MAX_NODES];
  logic [ID_W-1:0]   right_of  [1:MAX_NODES];
  bit                is_present [1:MAX_NODES];
  int                live_ids [$];

  link_result_t expected_links [$];

  int valid_gap_pct;
  int ready_drop_pct;
  int hold_request;
  int hold_left = 0;
  int errors = 0;
  int n_results = 0;
  int n_appends, n_queries, n_clears, n_nops, n_err_results;
  int n_pops, deepest_spine, most_nodes;
  bit rising_weights;

  function automatic link_result_t apply_tree_op(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                                 logic signed [31:0] w);
    link_result_t r;
    logic id_ok;
    logic [ID_W-1:0] popped;
    r = '0;
    id_ok = (id >= 1) && (id <= MAX_NODES);
    case (req)
      ctb_pkg::REQ_APPEND: begin
        if (!id_ok) begin
          r.status = ctb_pkg::ST_BAD_ID;
        end else if (n_nodes >= MAX_NODES) begin
          r.status = ctb_pkg::ST_FULL;
        end else if (is_present[id]) begin
          r.status = ctb_pkg::ST_BAD_ID;
        end else begin
          popped = '0;
          while (spine_top > 0 && spine_wt[spine_top-1] > w) begin
            spine_top--;
            popped = spine_id[spine_top];
            n_pops++;
          end
          if (popped != 0) parent_of[popped] = id;
          r.parent = (spine_top > 0) ? spine_id[spine_top-1] : '0;
          if (r.parent != 0) right_of[r.parent] = id;
          parent_of[id] = r.parent;
          left_of[id] = popped;
          right_of[id] = '0;
          is_present[id] = 1'b1;
          live_ids.push_back(int'(id));
          n_nodes++;
          spine_id[spine_top] = id;
          spine_wt[spine_top] = w;
          spine_top++;
          r.left = popped;
          n_appends++;
          if (spine_top > deepest_spine) deepest_spine = spine_top;
          if (n_nodes > most_nodes) most_nodes = n_nodes;
        end
      end
      ctb_pkg::REQ_QUERY: begin
        if (!id_ok) begin
          r.status = ctb_pkg::ST_BAD_ID;
        end else if (!is_present[id]) begin
          r.status = ctb_pkg::ST_ABSENT;
        end else begin
          r.parent = parent_of[id];
          r.left = left_of[id];
          r.right = right_of[id];
          n_queries++;
        end
      end
      ctb_pkg::REQ_CLEAR: begin
        spine_top = 0;
        n_nodes = 0;
        is_present = '{default: 1'b0};
        live_ids.delete();
        n_clears++;
      end
      default: n_nops++;
    endcase
    if (r.status != ctb_pkg::ST_OK) n_err_results++;
    r.root = (spine_top > 0) ? spine_id[0] : '0;
    return r;
  endfunction

  task automatic send_item(logic [REQ_W-1:0] req, logic [ID_W-1:0] id, logic signed [31:0] w);
    @(negedge clk);
    while ($urandom_range(99) < valid_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {5'b0, w, id};
    do @(posedge clk); while (!in_tready);
    expected_links.push_back(apply_tree_op(req, id, w));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_links.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int exp);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    link_result_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got.parent = out_tdata[10:0];
      got.left   = out_tdata[21:11];
      got.right  = out_tdata[32:22];
      got.root   = out_tdata[43:33];
      got.status = out_tdata[45:44];
      n_results++;
      if (expected_links.size() == 0) begin
        report_mismatch("unexpected item", int'(got.parent), 0);
      end else begin
        exp = expected_links.pop_front();
        if (got.parent != exp.parent)
          report_mismatch("parent_id", int'(got.parent), int'(exp.parent));
        if (got.left != exp.left)
          report_mismatch("left_id", int'(got.left), int'(exp.left));
        if (got.right != exp.right)
          report_mismatch("right_id", int'(got.right), int'(exp.right));
        if (got.root != exp.root)
          report_mismatch("root_id", int'(got.root), int'(exp.root));
        if (got.status != exp.status)
          report_mismatch("status", int'(got.status), int'(exp.status));
      end
    end
  end

  // receiver: random stalls plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= ready_drop_pct);
    end
  end

  function automatic logic signed [31:0] pick_weight();
    int v;
    case ($urandom_range(11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom;
      5, 6: begin
        // rising weights grow a deep spine; an extreme low then pops it all
        v = n_nodes * 4 + $urandom_range(5);
        return rising_weights ? v : $urandom_range(16) - 8;
      end
      default: begin
        v = $urandom_range(16);
        return v - 8;
      end
    endcase
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(MAX_NODES, 1)); while (is_present[id]);
    return id;
  endfunction

  task automatic test_directed_basics();
    valid_gap_pct = 0;
    ready_drop_pct = 0;
    send_item(REQ_NOP, 11'd5, 32'sd0);
    send_item(ctb_pkg::REQ_QUERY, 11'd1, 32'sd0);          // empty tree: absent
    send_item(ctb_pkg::REQ_APPEND, 11'd0, 32'sd3);         // id zero
    send_item(ctb_pkg::REQ_APPEND, 11'd1025, 32'sd3);      // just above range
    send_item(ctb_pkg::REQ_QUERY, 11'd2047, 32'sh7fffffff);
    send_item(ctb_pkg::REQ_QUERY, 11'd0, 32'sd0);
    send_item(ctb_pkg::REQ_APPEND, 11'd1, 32'sh7fffffff);
    send_item(ctb_pkg::REQ_APPEND, 11'd1024, 32'sh80000000);  // pops node 1
    send_item(ctb_pkg::REQ_APPEND, 11'd512, 32'sh80000000);   // equal weight stays
    send_item(ctb_pkg::REQ_APPEND, 11'd2, 32'sd0);
    send_item(ctb_pkg::REQ_APPEND, 11'd1024, 32'sd7);         // duplicate
    send_item(ctb_pkg::REQ_QUERY, 11'd1, 32'shffffffff);
    send_item(ctb_pkg::REQ_QUERY, 11'd1024, 32'sd0);
    send_item(ctb_pkg::REQ_QUERY, 11'd512, 32'sd0);
    send_item(ctb_pkg::REQ_QUERY, 11'd2, 32'sd0);
    send_item(ctb_pkg::REQ_QUERY, 11'd3, 32'sd0);
    send_item(REQ_NOP, 11'd2047, 32'shffffffff);
    send_item(ctb_pkg::REQ_CLEAR, 11'd2047, 32'shffffffff);
    send_item(ctb_pkg::REQ_QUERY, 11'd1, 32'sd0);
    send_item(ctb_pkg::REQ_APPEND, 11'd1, -32'sd1);
    send_item(ctb_pkg::REQ_QUERY, 11'd1, 32'sd0);
    drain_results();
  endtask

  task automatic test_store_full();
    int perm [1:MAX_NODES];
    int j, t;
    valid_gap_pct = 10;
    ready_drop_pct = 10;
    for (int i = 1; i <= MAX_NODES; i++) perm[i] = i;
    for (int i = MAX_NODES; i > 1; i--) begin
      j = $urandom_range(i, 1);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    send_item(ctb_pkg::REQ_CLEAR, '0, 32'sd0);
    rising_weights = 1'b0;
    for (int i = 1; i <= MAX_NODES; i++)
      send_item(ctb_pkg::REQ_APPEND, ID_W'(perm[i]), pick_weight());
    // full takes precedence over duplicate
    send_item(ctb_pkg::REQ_APPEND, ID_W'(perm[1]), 32'sd0);
    send_item(ctb_pkg::REQ_APPEND, 11'd0, 32'sd0);       // range check comes first
    for (int i = 0; i < 8; i++)
      send_item(ctb_pkg::REQ_QUERY, ID_W'($urandom_range(MAX_NODES, 1)), 32'sd0);
    send_item(ctb_pkg::REQ_CLEAR, '0, 32'sd0);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    valid_gap_pct = 0;
    ready_drop_pct = 0;
    @(negedge clk);
    hold_request = 300;
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0) send_item(ctb_pkg::REQ_APPEND, fresh_id(), pick_weight());
      else send_item(ctb_pkg::REQ_QUERY, ID_W'($urandom_range(MAX_NODES, 1)), $urandom);
    end
    // sender holds off until everything is back
    drain_results();
    repeat (20) @(posedge clk);
  endtask

  task automatic random_tree_op(ref int goal);
    int roll;
    roll = $urandom_range(99);
    if (n_nodes >= goal || roll < 2) begin
      send_item(ctb_pkg::REQ_CLEAR, ID_W'($urandom), $urandom);
      goal = ($urandom_range(9) == 0) ? $urandom_range(300, 60) : $urandom_range(60, 3);
      rising_weights = ($urandom_range(9) < 3);
    end else if (roll < 60) begin
      send_item(ctb_pkg::REQ_APPEND, fresh_id(), pick_weight());
    end else if (roll < 82 && live_ids.size() != 0) begin
      send_item(ctb_pkg::REQ_QUERY, ID_W'(live_ids[$urandom_range(live_ids.size() - 1)]),
                $urandom);
    end else if (roll < 86) begin
      send_item(ctb_pkg::REQ_QUERY, fresh_id(), $urandom);
    end else if (roll < 90) begin
      send_item(REQ_W'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 11'd0 : ID_W'($urandom_range(2047, 1025)),
                $urandom);
    end else if (roll < 93 && live_ids.size() != 0) begin
      send_item(ctb_pkg::REQ_APPEND, ID_W'(live_ids[$urandom_range(live_ids.size() - 1)]),
                pick_weight());
    end else if (roll < 95) begin
      send_item(REQ_NOP, ID_W'($urandom), $urandom);
    end else begin
      send_item(REQ_W'($urandom_range(3)), ID_W'($urandom), $urandom);
    end
  endtask

  task automatic test_random_phase(int count, int gap_pct, int drop_pct);
    int goal;
    valid_gap_pct = gap_pct;
    ready_drop_pct = drop_pct;
    goal = $urandom_range(60, 3);
    for (int i = 0; i < count; i++) random_tree_op(goal);
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    valid_gap_pct = 0;
    ready_drop_pct = 0;
    hold_request = 0;
    n_appends = 0; n_queries = 0; n_clears = 0; n_nops = 0; n_err_results = 0;
    n_pops = 0; deepest_spine = 0; most_nodes = 0;
    rising_weights = 1'b0;
    spine_top = 0;
    n_nodes = 0;
    is_present = '{default: 1'b0};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed_basics();
    test_output_backpressure();
    test_random_phase(180, 0, 0);
    test_random_phase(180, 85, 0);
    test_random_phase(180, 0, 85);
    test_store_full();
    test_random_phase(180, 10, 10);

    drain_results();
    repeat (64) @(posedge clk);
    $display("Checked %0d results: %0d appends, %0d queries, %0d clears, %0d no-ops, %0d errors",
             n_results, n_appends, n_queries, n_clears, n_nops, n_err_results);
    $display("Spine depth reached %0d, %0d entries popped, largest tree %0d nodes",
             deepest_spine, n_pops, most_nodes);
    if (errors == 0) begin
      $display("** cartesian_tree_builder: PASSED **");
    end else begin
      $display("** cartesian_tree_builder: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ctb_pkg.sv
design/ctb_ctrl.sv
design/ctb_dp.sv
design/cartesian_tree_builder.sv
bench/tb_cartesian_tree_builder.sv
